// ===== design/keyed_weighted_random_pick_unit_defines.svh =====
// assertion macros for the weighted pick unit
`ifndef KEYED_WEIGHTED_RANDOM_PICK_UNIT_DEFINES_SVH
`define KEYED_WEIGHTED_RANDOM_PICK_UNIT_DEFINES_SVH
`define KWRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define KWRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/kwrp_pkg.sv =====
// ----------------------------------------------------------------------------
// kwrp_pkg
// shared types and constants of the weighted pick unit
// ----------------------------------------------------------------------------
`default_nettype none
package kwrp_pkg;
  localparam int MAX_TABLES = 64;
  localparam int MAX_ENTRIES = 16;
  localparam int TW = $clog2(MAX_TABLES);
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int AW = TW + EW;
  localparam int CW = TW + 1;
  localparam int NW = EW + 1;
  localparam int HDR_W = 64 + NW;

  localparam logic [1:0] FUNC_HEADER = 2'd0;
  localparam logic [1:0] FUNC_ENTRY  = 2'd1;
  localparam logic [1:0] FUNC_ROLL   = 2'd2;

  localparam logic [2:0] ST_TAKEN    = 3'd0;
  localparam logic [2:0] ST_PICKED   = 3'd1;
  localparam logic [2:0] ST_NO_TABLE = 3'd2;
  localparam logic [2:0] ST_ZERO_SUM = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

// ===== design/kwrp_ram.sv =====
// ----------------------------------------------------------------------------
// kwrp_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module kwrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/kwrp_mod.sv =====
// ----------------------------------------------------------------------------
// kwrp_mod
// serial 32-bit remainder, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module kwrp_mod (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  kwrp_pkg::div_req_t     req,
  output logic                   done,
  output logic [31:0]            rem
);
  import kwrp_pkg::*;
  logic [31:0] q_r, q_nxt, d_r, d_nxt;
  logic [32:0] r_r, r_nxt, sh;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt = q_r;
    d_nxt = d_r;
    r_nxt = r_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {r_r[31:0], q_r[31]};
    if (req.start) begin
      q_nxt = req.dividend;
      d_nxt = req.divisor;
      r_nxt = '0;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[30:0], 1'b0};
      r_nxt = (sh >= {1'b0, d_r}) ? sh - {1'b0, d_r} : sh;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    d_r <= d_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign rem = r_r[31:0];
endmodule
`default_nettype wire

// ===== design/keyed_weighted_random_pick_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_weighted_random_pick_unit
// ordered store of weighted tables with roulette wheel selection
// ----------------------------------------------------------------------------
// One request at a time; a new request is taken only after the previous
// result has been handed off. A header load goes straight to S_OUT; an entry
// load reads the last header (S_ELOAD) and, if it is not full, writes entry
// and header (S_EWR) first. A roll reads headers in S_HSCAN and S_HCHK (up
// to 64), sums weights one per cycle (up to 16), waits on the 32-step serial
// remainder and rescans entries one per cycle (up to 16); the single port
// header and entry memories set the scan rates.
`default_nettype none
module keyed_weighted_random_pick_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_group_key,
  input  wire logic [31:0] in_table_id,
  input  wire logic [31:0] in_item_code,
  input  wire logic [31:0] in_weight,
  input  wire logic [31:0] in_random_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_picked_item,
  output logic [2:0]       out_status
);
  import kwrp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_ELOAD = 4'd1, S_EWR = 4'd2,
    S_HSCAN = 4'd3, S_HCHK = 4'd4, S_SUM = 4'd5, S_DIV = 4'd6,
    S_PICK = 4'd7, S_OUT = 4'd8, S_DIVW = 4'd9;

  logic [3:0]  st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic [NW-1:0] e_r, e_nxt, n_r, n_nxt;
  logic [31:0] grp_r, grp_nxt, id_r, id_nxt, code_r, code_nxt, wt_r, wt_nxt;
  logic [31:0] rnd_r, rnd_nxt, acc_r, acc_nxt, pick_r, pick_nxt;
  logic [31:0] oitem_r, oitem_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic        ov_r, ov_nxt;

  logic            h_we, e_we;
  logic [TW-1:0]   h_addr;
  logic [HDR_W-1:0] h_wd, h_rd;
  logic [AW-1:0]   e_addr;
  logic [63:0]     e_wd, e_rd;
  logic [31:0]     h_grp, h_id, e_w, e_i, acc_add;
  logic [NW-1:0]   h_n;
  div_req_t        dreq;
  logic            ddone;
  logic [31:0]     drem;

  assign {h_grp, h_id, h_n} = h_rd;
  assign {e_i, e_w} = e_rd;
  assign acc_add = acc_r + e_w;

  kwrp_ram #(.WIDTH(HDR_W), .DEPTH(MAX_TABLES)) u_hdr (
    .clk, .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd));
  kwrp_ram #(.WIDTH(64), .DEPTH(MAX_TABLES * MAX_ENTRIES)) u_ent (
    .clk, .we(e_we), .addr(e_addr), .wdata(e_wd), .rdata(e_rd));
  kwrp_mod u_mod (.clk, .rst_n, .req(dreq), .done(ddone), .rem(drem));

  assign in_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_picked_item = oitem_r;
  assign out_status = ost_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; t_nxt = t_r; e_nxt = e_r; n_nxt = n_r;
    grp_nxt = grp_r; id_nxt = id_r; code_nxt = code_r;
    wt_nxt = wt_r; rnd_nxt = rnd_r; acc_nxt = acc_r; pick_nxt = pick_r;
    oitem_nxt = oitem_r; ost_nxt = ost_r; ov_nxt = ov_r;
    h_we = 1'b0; h_addr = t_r; h_wd = {grp_r, id_r, n_r};
    e_we = 1'b0; e_addr = {t_r, e_r[EW-1:0]}; e_wd = {code_r, wt_r};
    dreq = '{start: 1'b0, dividend: rnd_r, divisor: acc_r};
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          grp_nxt = in_group_key; id_nxt = in_table_id;
          code_nxt = in_item_code; wt_nxt = in_weight; rnd_nxt = in_random_value;
          oitem_nxt = '0;
          st_nxt = S_OUT;
          case (in_func)
            FUNC_HEADER: begin
              if (cnt_r == CW'(MAX_TABLES)) begin
                ost_nxt = ST_FULL;
              end else begin
                h_we = 1'b1; h_addr = cnt_r[TW-1:0];
                h_wd = {in_group_key, in_table_id, NW'(0)};
                cnt_nxt = cnt_r + CW'(1);
                ost_nxt = ST_TAKEN;
              end
            end
            FUNC_ENTRY: begin
              if (cnt_r == '0) begin
                ost_nxt = ST_NO_TABLE;
              end else begin
                t_nxt = TW'(cnt_r - CW'(1));
                h_addr = TW'(cnt_r - CW'(1));
                st_nxt = S_ELOAD;
              end
            end
            FUNC_ROLL: begin
              ost_nxt = ST_NO_TABLE;
              if (cnt_r != '0) begin
                t_nxt = '0; h_addr = '0; st_nxt = S_HSCAN;
              end
            end
            default: ost_nxt = ST_NO_TABLE;
          endcase
        end
      end
      S_ELOAD: begin
        if (h_n == NW'(MAX_ENTRIES)) begin
          ost_nxt = ST_FULL; st_nxt = S_OUT;
        end else begin
          n_nxt = h_n; e_nxt = h_n; grp_nxt = h_grp; id_nxt = h_id;
          st_nxt = S_EWR;
        end
      end
      S_EWR: begin
        e_we = 1'b1;
        h_we = 1'b1; h_wd = {grp_r, id_r, n_r + NW'(1)};
        ost_nxt = ST_TAKEN; st_nxt = S_OUT;
      end
      S_HSCAN: begin
        st_nxt = S_HCHK;
      end
      S_HCHK: begin
        if ((h_grp == grp_r || h_grp == '0) && h_id == id_r) begin
          n_nxt = h_n; e_nxt = '0; acc_nxt = '0;
          e_addr = {t_r, {EW{1'b0}}};
          if (h_n == '0) begin
            ost_nxt = ST_ZERO_SUM; st_nxt = S_OUT;
          end else begin
            st_nxt = S_SUM;
          end
        end else if ({1'b0, t_r} + CW'(1) == cnt_r) begin
          ost_nxt = ST_NO_TABLE; st_nxt = S_OUT;
        end else begin
          t_nxt = t_r + TW'(1); h_addr = t_r + TW'(1); st_nxt = S_HSCAN;
        end
      end
      S_SUM: begin
        acc_nxt = acc_add;
        e_nxt = e_r + NW'(1);
        e_addr = {t_r, EW'(e_r + NW'(1))};
        if (e_r + NW'(1) == n_r) begin
          if (acc_add == '0) begin
            ost_nxt = ST_ZERO_SUM; st_nxt = S_OUT;
          end else begin
            dreq.start = 1'b1; dreq.divisor = acc_add;
            st_nxt = S_DIVW;
          end
        end
      end
      S_DIVW: begin
        e_nxt = '0; acc_nxt = '0; st_nxt = S_DIV;
      end
      S_DIV: begin
        e_addr = {t_r, EW'(e_r)};
        if (ddone) begin
          pick_nxt = drem; st_nxt = S_PICK;
        end
      end
      S_PICK: begin
        acc_nxt = acc_add;
        e_nxt = e_r + NW'(1);
        e_addr = {t_r, EW'(e_r + NW'(1))};
        if (pick_r < acc_add || e_r + NW'(1) == n_r) begin
          oitem_nxt = e_i; ost_nxt = ST_PICKED; st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
    t_r <= t_nxt; e_r <= e_nxt; n_r <= n_nxt;
    grp_r <= grp_nxt; id_r <= id_nxt; code_r <= code_nxt; wt_r <= wt_nxt;
    rnd_r <= rnd_nxt; acc_r <= acc_nxt; pick_r <= pick_nxt;
    oitem_r <= oitem_nxt; ost_r <= ost_nxt;
  end
endmodule
`default_nettype wire

// ===== design/kwrp_checker.sv =====
// ----------------------------------------------------------------------------
// kwrp_checker
// port level checks of the weighted pick unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyed_weighted_random_pick_unit_defines.svh"
module kwrp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_picked_item,
  input wire logic [2:0]  out_status
);
  import kwrp_pkg::*;
  `KWRP_ASSERT_IMPL(a_stat_range, clk, rst_n, out_valid, out_status <= ST_FULL, "bad status")
  `KWRP_ASSERT_IMPL(a_item_zero, clk, rst_n, out_valid && out_status != ST_PICKED, out_picked_item == '0, "item on non pick")
  `KWRP_ASSERT_NEXT(a_one_req, clk, rst_n, in_valid && in_ready, !in_ready, "second request taken")
  `KWRP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status), "result dropped")
endmodule
bind keyed_weighted_random_pick_unit kwrp_checker u_kwrp_checker (.*);
`default_nettype wire

// ===== test/keyed_weighted_random_pick_unit_tb.sv =====
// ----------------------------------------------------------------------------
// keyed_weighted_random_pick_unit_tb
// drives header, entry and roll requests with random gaps and output stalls,
// predicts results from a local copy of the table store or takes them from the directed rows, and compares them
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_weighted_random_pick_unit_tb;
  import kwrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_RANDOM = 430;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] group_key;
    logic [31:0] table_id;
    logic [31:0] item_code;
    logic [31:0] weight;
    logic [31:0] random_value;
    bit          has_exp;
    logic [31:0] exp_item;
    logic [2:0]  exp_status;
  } stim_row_t;

  typedef struct {
    logic [31:0] picked_item;
    logic [2:0]  status;
  } pick_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = '0;
  logic [31:0] in_group_key = '0;
  logic [31:0] in_table_id = '0;
  logic [31:0] in_item_code = '0;
  logic [31:0] in_weight = '0;
  logic [31:0] in_random_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_picked_item;
  logic [2:0]  out_status;

  // local copy of the table store
  int          num_tables;
  logic [31:0] tbl_group [MAX_TABLES];
  logic [31:0] tbl_ident [MAX_TABLES];
  int          tbl_fill [MAX_TABLES];
  logic [31:0] ent_item [MAX_TABLES*MAX_ENTRIES];
  logic [31:0] ent_weight [MAX_TABLES*MAX_ENTRIES];

  pick_result_t expected_picks[$];
  stim_row_t   dir_rows[$];
  int          errors = 0;
  int          idle_cycles = 0;

  keyed_weighted_random_pick_unit uut (.*);

  always #4 clk = ~clk;

  function automatic pick_result_t predict_pick(logic [1:0] func, logic [31:0] grp,
      logic [31:0] ident, logic [31:0] code, logic [31:0] wt, logic [31:0] rnd);
    pick_result_t r;
    int t;
    int n;
    logic [31:0] total;
    logic [31:0] pick;
    logic [31:0] accum;
    r.picked_item = '0;
    r.status = ST_NO_TABLE;
    if (func == FUNC_HEADER) begin
      if (num_tables >= MAX_TABLES) begin
        r.status = ST_FULL;
      end else begin
        tbl_group[num_tables] = grp;
        tbl_ident[num_tables] = ident;
        tbl_fill[num_tables] = 0;
        num_tables++;
        r.status = ST_TAKEN;
      end
    end else if (func == FUNC_ENTRY) begin
      if (num_tables != 0) begin
        t = num_tables - 1;
        n = tbl_fill[t];
        if (n >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          ent_item[t*MAX_ENTRIES+n] = code;
          ent_weight[t*MAX_ENTRIES+n] = wt;
          tbl_fill[t] = n + 1;
          r.status = ST_TAKEN;
        end
      end
    end else if (func == FUNC_ROLL) begin
      for (t = 0; t < num_tables; t++)
        if ((tbl_group[t] == grp || tbl_group[t] == 0) && tbl_ident[t] == ident) break;
      if (t < num_tables) begin
        total = '0;
        for (int e = 0; e < tbl_fill[t]; e++) total += ent_weight[t*MAX_ENTRIES+e];
        if (total == 0) begin
          r.status = ST_ZERO_SUM;
        end else begin
          pick = rnd % total;
          accum = '0;
          r.status = ST_PICKED;
          for (int e = 0; e < tbl_fill[t]; e++) begin
            accum += ent_weight[t*MAX_ENTRIES+e];
            if (pick < accum) begin
              r.picked_item = ent_item[t*MAX_ENTRIES+e];
              break;
            end
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(stim_row_t s);
    pick_result_t r;
    int gap;
    gap = $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= s.func;
    in_group_key <= s.group_key;
    in_table_id <= s.table_id;
    in_item_code <= s.item_code;
    in_weight <= s.weight;
    in_random_value <= s.random_value;
    r = predict_pick(s.func, s.group_key, s.table_id, s.item_code, s.weight,
                     s.random_value);
    if (s.has_exp) begin
      r.picked_item = s.exp_item;
      r.status = s.exp_status;
    end
    expected_picks.insert(expected_picks.size(), r);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic stim_row_t row(logic [1:0] f, logic [31:0] g, logic [31:0] id,
      logic [31:0] c, logic [31:0] w, logic [31:0] rv, bit he = 0,
      logic [31:0] ei = 0, logic [2:0] es = 0);
    stim_row_t s;
    s.func = f; s.group_key = g; s.table_id = id; s.item_code = c;
    s.weight = w; s.random_value = rv; s.has_exp = he;
    s.exp_item = ei; s.exp_status = es;
    return s;
  endfunction

  function automatic void add_row(stim_row_t s);
    dir_rows.insert(dir_rows.size(), s);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // output side: a random stall before each result is taken
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    pick_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result: picked_item %h status %0d", out_picked_item,
               out_status);
        errors++;
      end else begin
        e = expected_picks.pop_front();
        if (out_picked_item !== e.picked_item) begin
          $error("picked_item expected %h actual %h", e.picked_item, out_picked_item);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t s;
    int kind;
    int ids;
    num_tables = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(row(FUNC_ROLL, 0, 0, 0, 0, 0, 1, 0, ST_NO_TABLE));
    add_row(row(FUNC_ENTRY, 0, 0, 5, 5, 0, 1, 0, ST_NO_TABLE));
    add_row(row(FUNC_SPARE, '1, '1, '1, '1, '1, 1, 0, ST_NO_TABLE));
    add_row(row(FUNC_HEADER, 7, 1, 0, 0, 0, 1, 0, ST_TAKEN));
    add_row(row(FUNC_ROLL, 7, 1, 0, 0, 9, 1, 0, ST_ZERO_SUM));
    add_row(row(FUNC_ENTRY, 0, 0, 'hAA, 0, 0, 1, 0, ST_TAKEN));
    add_row(row(FUNC_ROLL, 7, 1, 0, 0, 9, 1, 0, ST_ZERO_SUM));
    add_row(row(FUNC_ENTRY, 0, 0, 'hBB, 3, 0, 1, 0, ST_TAKEN));
    add_row(row(FUNC_ROLL, 7, 1, 0, 0, '1, 1, 'hBB, ST_PICKED));
    add_row(row(FUNC_ROLL, 8, 1, 0, 0, 0, 1, 0, ST_NO_TABLE));
    add_row(row(FUNC_HEADER, 0, '1, 0, 0, 0, 1, 0, ST_TAKEN));
    add_row(row(FUNC_ENTRY, 0, 0, '1, '1, 0, 1, 0, ST_TAKEN));
    add_row(row(FUNC_ENTRY, 0, 0, 0, 1, 0, 1, 0, ST_TAKEN));
    add_row(row(FUNC_ROLL, 'h1234, '1, 0, 0, 0, 1, 0, ST_ZERO_SUM));
    add_row(row(FUNC_ENTRY, 0, 0, 'h77, 2, 0));
    add_row(row(FUNC_ROLL, '1, '1, 0, 0, 'hFFFFFFFE));
    add_row(row(FUNC_ROLL, 5, '1, 0, 0, 1));
    for (int i = 0; i < 17; i++) add_row(row(FUNC_ENTRY, 0, 0, i, i, 0));
    foreach (dir_rows[i]) send_request(dir_rows[i]);

    // random phase: headers, entries and, most often, rolls, over a small id set
    for (int i = 0; i < NUM_RANDOM; i++) begin
      ids = $urandom_range(0, 7);
      kind = $urandom_range(0, 19);
      if (kind < 3)
        s = row(FUNC_HEADER, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3),
                ids, 0, 0, 0);
      else if (kind < 10)
        s = row(FUNC_ENTRY, rand_word(), rand_word(), rand_word(),
                ($urandom_range(0, 4) == 0) ? rand_word() : $urandom_range(0, 20),
                rand_word());
      else if (kind < 19)
        s = row(FUNC_ROLL, $urandom_range(0, 3), ids, rand_word(), rand_word(),
                rand_word());
      else
        s = row(2'($urandom_range(0, 3)), rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word());
      send_request(s);
    end
    in_valid <= 1'b0;

    while (expected_picks.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
